// ----- src/dps_pkg.sv -----
// Delimiter page splitter: shared widths, register indexes, status codes and types.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package dps_pkg;

  localparam int DELIM_MAX_DEFAULT = 8;   // longest delimiter supported by default
  localparam int DELIM_BYTES       = 8;   // bytes held by the delimiter register
  localparam int DATA_W            = 8;
  localparam int LEN_W             = 4;
  localparam int DPP_W             = 16;
  localparam int LIMIT_W           = 31;
  localparam int CNT_W             = 32;
  localparam int STATUS_W          = 2;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;
  localparam int KB_SHIFT          = 10;
  localparam int QUEUE_DEPTH       = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELIMS_PAGE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_PAGES  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ABORT_LIMIT  = 3'd5;

  // stop state / reported status
  localparam logic [STATUS_W-1:0] ST_RUN   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TRUNC = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABORT = 2'd2;

  // input item kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [CNT_W-1:0] CNT_MAX        = 32'hffff_ffff;
  localparam logic [CNT_W-1:0] PAGE_UNLIMITED = 32'h7fff_ffff;

  localparam logic [CFG_DATA_W-1:0] DELIM_BYTES_RST = 64'd12;
  localparam logic [LEN_W-1:0]      DELIM_LEN_RST   = 4'd1;
  localparam logic [DPP_W-1:0]      DELIMS_PAGE_RST = 16'd1;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] delimiter_bytes;
    logic [LEN_W-1:0]      delimiter_length;
    logic [DPP_W-1:0]      delims_per_page;
    logic [LIMIT_W-1:0]    size_limit;
    logic                  limit_in_pages;
    logic                  abort_on_limit;
  } dps_cfg_t;

  // classified item as it travels from front end to back end
  typedef struct packed {
    logic                   is_end;
    logic [DATA_W-1:0]      data;
    logic [DELIM_BYTES-1:0] eq;     // data equals delimiter byte i
  } dps_item_t;

endpackage
`default_nettype wire

// ----- src/dps_if.sv -----
// Delimiter page splitter: valid/ready channel interfaces for input and result items.
// Depends on dps_pkg for field widths.
`default_nettype none
interface dps_in_if;
  import dps_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [DATA_W-1:0] data_in;

  modport source (output valid, kind, data_in, input ready);
  modport sink   (input valid, kind, data_in, output ready);
endinterface

interface dps_out_if;
  import dps_pkg::*;
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   data_out;
  logic                write_byte;
  logic                page_end;
  logic [CNT_W-1:0]    byte_offset;
  logic [CNT_W-1:0]    page_count;
  logic [DPP_W-1:0]    last_page_records;
  logic [STATUS_W-1:0] status;
  logic                done_res;

  modport source (output valid, data_out, write_byte, page_end, byte_offset, page_count,
                  last_page_records, status, done_res, input ready);
  modport sink   (input valid, data_out, write_byte, page_end, byte_offset, page_count,
                  last_page_records, status, done_res, output ready);
endinterface
`default_nettype wire

// ----- src/delimiter_page_splitter_top.sv -----
// Delimiter page splitter top level: configuration registers and the front end,
// queue and back end. Depends on dps_pkg, dps_if, dps_front, dps_queue, dps_back.
//
// One byte or end-of-stream transaction is taken per clock while the result channel does
// not stall, and one result comes back for each, in order. The rate of one item per cycle
// is set by the back end, which updates the delimiter matcher (all fallback lengths tested
// in parallel) and the byte, page and limit counters together for each item. An accepted
// item is written into the two-entry queue, and the back end then loads its result into
// the result register.
// The queue lets input keep flowing while a result waits to be taken. No clearing
// pass follows reset. Write configuration only while no transaction is in flight.
`default_nettype none
module delimiter_page_splitter_top #(
  parameter int MAX_DELIM_LEN = dps_pkg::DELIM_MAX_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  dps_in_if.sink                           in_ch,
  dps_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [dps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import dps_pkg::*;

  dps_cfg_t  cfg_r;
  logic      push_valid, push_ready;
  dps_item_t push_item;
  logic      pop_valid, pop_ready;
  dps_item_t pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delimiter_bytes  <= DELIM_BYTES_RST;
      cfg_r.delimiter_length <= DELIM_LEN_RST;
      cfg_r.delims_per_page  <= DELIMS_PAGE_RST;
      cfg_r.size_limit       <= '0;
      cfg_r.limit_in_pages   <= 1'b0;
      cfg_r.abort_on_limit   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DELIM_BYTES:  cfg_r.delimiter_bytes  <= cfg_wdata;
        REG_DELIM_LENGTH: cfg_r.delimiter_length <= cfg_wdata[LEN_W-1:0];
        REG_DELIMS_PAGE:  cfg_r.delims_per_page  <= cfg_wdata[DPP_W-1:0];
        REG_SIZE_LIMIT:   cfg_r.size_limit       <= cfg_wdata[LIMIT_W-1:0];
        REG_LIMIT_PAGES:  cfg_r.limit_in_pages   <= cfg_wdata[0];
        REG_ABORT_LIMIT:  cfg_r.abort_on_limit   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  dps_front u_front (
    .in_ch      (in_ch),
    .cfg        (cfg_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  dps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  dps_back #(
    .MAX_DELIM_LEN (MAX_DELIM_LEN)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (pop_valid),
    .item_ready (pop_ready),
    .item       (pop_item),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire

// ----- src/dps_front.sv -----
// Delimiter page splitter front end: accepts input transactions and classifies them.
// Depends on dps_pkg and dps_in_if; feeds dps_queue.
`default_nettype none
module dps_front (
  dps_in_if.sink              in_ch,
  input  dps_pkg::dps_cfg_t   cfg,
  output logic                push_valid,
  input  logic                push_ready,
  output dps_pkg::dps_item_t  push_item
);
  import dps_pkg::*;

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  // compare the byte against every delimiter position up front
  always_comb begin
    push_item.is_end = (in_ch.kind == KIND_END);
    push_item.data   = in_ch.data_in;
    for (int i = 0; i < DELIM_BYTES; i++) begin
      push_item.eq[i] = (in_ch.data_in == cfg.delimiter_bytes[DATA_W*i +: DATA_W]);
    end
  end

endmodule
`default_nettype wire

// ----- src/dps_queue.sv -----
// Delimiter page splitter: short queue of classified items between front and back end.
// Depends on dps_pkg.
`default_nettype none
module dps_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  dps_pkg::dps_item_t  push_item,
  output logic                pop_valid,
  input  logic                pop_ready,
  output dps_pkg::dps_item_t  pop_item
);
  import dps_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_QW-1:0] FULL = CNT_QW'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0]  LAST = PTR_W'(QUEUE_DEPTH - 1);

  dps_item_t          mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0]  count_r, count_nxt;
  logic               push, pop;

  assign push_ready = (count_r != FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ----- src/dps_back.sv -----
// Delimiter page splitter back end: delimiter matcher, page and limit counters,
// and the result register. Depends on dps_pkg and dps_out_if; fed by dps_queue.
`default_nettype none
module dps_back #(
  parameter int MAX_DELIM_LEN = dps_pkg::DELIM_MAX_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dps_pkg::dps_cfg_t   cfg,
  input  logic                item_valid,
  output logic                item_ready,
  input  dps_pkg::dps_item_t  item,
  dps_out_if.source           out_ch
);
  import dps_pkg::*;

  // fallback reads at most MAX_DELIM_LEN - 2 of the bytes before the current one
  localparam int HIST_BYTES = (MAX_DELIM_LEN > 2) ? MAX_DELIM_LEN - 2 : 1;
  localparam int HIST_W     = DATA_W * HIST_BYTES;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_DELIM_LEN);

  // matcher and counter state
  logic [LEN_W-1:0]    match_r, match_nxt;
  logic [HIST_W-1:0]   hist_r, hist_nxt;
  logic [DPP_W-1:0]    rec_r, rec_nxt;
  logic [CNT_W-1:0]    bop_r, bop_nxt;
  logic [CNT_W-1:0]    total_r, total_nxt;
  logic [CNT_W-1:0]    pages_r, pages_nxt;
  logic [STATUS_W-1:0] stop_r, stop_nxt;

  // result register
  logic                out_valid_r;
  logic [DATA_W-1:0]   dout_r, dout_nxt;
  logic                wr_r, wr_nxt;
  logic                pend_r, pend_nxt;
  logic [CNT_W-1:0]    offset_r, offset_nxt;
  logic [CNT_W-1:0]    pcount_r, pcount_nxt;
  logic [DPP_W-1:0]    lastrec_r, lastrec_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                done_r, done_nxt;

  logic                fire;
  logic [LEN_W-1:0]    len_eff, m_cur, m_inc, fb_len;
  logic [CNT_W:0]      next_total;
  logic [CNT_W+KB_SHIFT-1:0] klim;
  logic [CNT_W-1:0]    plim, pages_inc;
  logic [DPP_W-1:0]    rec_inc;
  logic                over, hit, pref_ok;
  logic [STATUS_W-1:0] stop_code;

  assign item_ready = !out_valid_r || out_ch.ready;
  assign fire       = item_valid && item_ready;

  // effective delimiter length, clamped to 1..MAX_DELIM_LEN
  always_comb begin
    len_eff = cfg.delimiter_length;
    if (len_eff == '0) begin
      len_eff = LEN_W'(1);
    end
    if (len_eff > LEN_MAX) begin
      len_eff = LEN_MAX;
    end
  end

  // longest shorter prefix that ends on the current byte; all candidates in parallel
  always_comb begin
    fb_len = '0;
    for (int r = 0; r < MAX_DELIM_LEN - 1; r++) begin
      pref_ok = item.eq[r] && (LEN_W'(r) < m_cur);
      for (int j = 0; j < r; j++) begin
        if (cfg.delimiter_bytes[DATA_W*j +: DATA_W] != hist_r[DATA_W*(r-1-j) +: DATA_W]) begin
          pref_ok = 1'b0;
        end
      end
      if (pref_ok) begin
        fb_len = LEN_W'(r + 1);
      end
    end
  end

  always_comb begin
    // stale match left by a register change acts as length - 1
    m_cur      = (match_r >= len_eff) ? len_eff - 1'b1 : match_r;
    hit        = item.eq[m_cur[2:0]];
    m_inc      = m_cur + 1'b1;
    next_total = {1'b0, total_r} + 1'b1;
    klim       = (CNT_W+KB_SHIFT)'(CNT_MAX);
    plim       = PAGE_UNLIMITED;
    if (cfg.size_limit != '0) begin
      if (cfg.limit_in_pages) begin
        plim = {1'b0, cfg.size_limit};
      end else begin
        klim = {1'b0, cfg.size_limit, {KB_SHIFT{1'b0}}};
      end
    end
    over      = next_total[CNT_W] || ((CNT_W+KB_SHIFT)'(next_total) > klim);
    pages_inc = (pages_r == CNT_MAX) ? pages_r : pages_r + 1'b1;
    rec_inc   = rec_r + 1'b1;
    stop_code = cfg.abort_on_limit ? ST_ABORT : ST_TRUNC;

    match_nxt = match_r;
    hist_nxt  = hist_r;
    rec_nxt   = rec_r;
    bop_nxt   = bop_r;
    total_nxt = total_r;
    pages_nxt = pages_r;
    stop_nxt  = stop_r;

    dout_nxt    = '0;
    wr_nxt      = 1'b0;
    pend_nxt    = 1'b0;
    lastrec_nxt = '0;
    done_nxt    = 1'b0;

    if (item.is_end) begin
      done_nxt = 1'b1;
      if (stop_r != ST_ABORT && bop_r != '0) begin
        pages_nxt = pages_inc;
        if (cfg.delims_per_page > rec_r) begin
          lastrec_nxt = cfg.delims_per_page - rec_r;
        end
      end
    end else begin
      dout_nxt = item.data;
      if (stop_r == ST_RUN) begin
        if (over) begin
          stop_nxt = stop_code;
        end else begin
          total_nxt = next_total[CNT_W-1:0];
          bop_nxt   = (bop_r == CNT_MAX) ? bop_r : bop_r + 1'b1;
          wr_nxt    = 1'b1;
          hist_nxt  = (hist_r << DATA_W) | HIST_W'(item.data);
          if (hit) begin
            match_nxt = m_inc;
            if (m_inc >= len_eff) begin
              match_nxt = '0;
              rec_nxt   = rec_inc;
              if (rec_inc >= cfg.delims_per_page) begin
                pend_nxt  = 1'b1;
                bop_nxt   = '0;
                rec_nxt   = '0;
                pages_nxt = pages_inc;
                if (pages_inc > plim) begin
                  stop_nxt = stop_code;
                  wr_nxt   = 1'b0;
                end
              end
            end
          end else begin
            match_nxt = fb_len;
          end
        end
      end
    end

    offset_nxt = total_nxt;
    pcount_nxt = pages_nxt;
    status_nxt = stop_nxt;

    // end of stream: back to the reset state for the next one
    if (item.is_end) begin
      match_nxt = '0;
      hist_nxt  = '0;
      rec_nxt   = '0;
      bop_nxt   = '0;
      total_nxt = '0;
      pages_nxt = '0;
      stop_nxt  = ST_RUN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r     <= '0;
      hist_r      <= '0;
      rec_r       <= '0;
      bop_r       <= '0;
      total_r     <= '0;
      pages_r     <= '0;
      stop_r      <= ST_RUN;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        match_r <= match_nxt;
        hist_r  <= hist_nxt;
        rec_r   <= rec_nxt;
        bop_r   <= bop_nxt;
        total_r <= total_nxt;
        pages_r <= pages_nxt;
        stop_r  <= stop_nxt;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      dout_r    <= dout_nxt;
      wr_r      <= wr_nxt;
      pend_r    <= pend_nxt;
      offset_r  <= offset_nxt;
      pcount_r  <= pcount_nxt;
      lastrec_r <= lastrec_nxt;
      status_r  <= status_nxt;
      done_r    <= done_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.data_out          = dout_r;
  assign out_ch.write_byte        = wr_r;
  assign out_ch.page_end          = pend_r;
  assign out_ch.byte_offset       = offset_r;
  assign out_ch.page_count        = pcount_r;
  assign out_ch.last_page_records = lastrec_r;
  assign out_ch.status            = status_r;
  assign out_ch.done_res          = done_r;

endmodule
`default_nettype wire

// ----- verif/delimiter_page_splitter_top_tb.sv -----
// Self-checking testbench for delimiter_page_splitter_top: byte and end-of-stream
// transactions go in, each result is compared field by field with a local model or a fixed row.
// Depends on dps_pkg, dps_if and the RTL of the block.
`default_nettype none
module delimiter_page_splitter_top_tb;
  import dps_pkg::*;

  localparam int CLK_HALF    = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 6;
  localparam int MAX_LEN     = DELIM_MAX_DEFAULT;

  typedef struct packed {
    logic [DATA_W-1:0]   data_out;
    logic                write_byte;
    logic                page_end;
    logic [CNT_W-1:0]    byte_offset;
    logic [CNT_W-1:0]    page_count;
    logic [DPP_W-1:0]    last_page_records;
    logic [STATUS_W-1:0] status;
    logic                done_res;
  } split_result_t;

  typedef struct packed {
    logic                  is_write;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  kind;
    logic [DATA_W-1:0]     data;
    logic                  fixed;
    split_result_t         want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  res_ready = 1'b0;

  dps_in_if  in_ch ();
  dps_out_if out_ch ();

  assign out_ch.ready = res_ready;

  delimiter_page_splitter_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the registers and of the splitter state
  dps_cfg_t         cfg_sh = '{DELIM_BYTES_RST, DELIM_LEN_RST, DELIMS_PAGE_RST, '0, 1'b0, 1'b0};
  logic [LEN_W-1:0] match_len  = '0;
  logic [63:0]      hist       = '0;
  logic [DPP_W-1:0] rec_cnt    = '0;
  logic [CNT_W-1:0] page_bytes = '0;
  logic [CNT_W-1:0] byte_total = '0;
  logic [CNT_W-1:0] page_total = '0;
  logic [1:0]       stop_st    = ST_RUN;

  split_result_t results_due[$];
  stim_row_t     opening_rows[$];
  int            errors      = 0;
  int            items_sent  = 0;
  int            cycle_cnt   = 0;
  int            stall_left  = 0;
  bit            gaps_on     = 1'b1;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic logic [7:0] delim_byte(input int i);
    logic [63:0] sh;
    sh = cfg_sh.delimiter_bytes >> (8 * (i % 8));
    return sh[7:0];
  endfunction

  function automatic logic [7:0] hist_byte(input int i);
    logic [63:0] sh;
    sh = hist >> (8 * (i % 8));
    return sh[7:0];
  endfunction

  function automatic int eff_length();
    int n;
    n = int'(cfg_sh.delimiter_length);
    if (n == 0) n = 1;
    if (n > MAX_LEN) n = MAX_LEN;
    return n;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // longest shorter prefix that ends the bytes seen and continues with ch, down to length one
  function automatic int prefix_fallback(input int m, input logic [7:0] ch);
    int  r;
    int  j;
    bit  ok;
    for (r = m - 1; r >= 0; r--) begin
      if (delim_byte(r) == ch) begin
        ok = 1'b1;
        for (j = 0; j < r; j++)
          if (delim_byte(j) != hist_byte(r - 1 - j)) ok = 1'b0;
        if (ok) return r + 1;
      end
    end
    return 0;
  endfunction

  function automatic split_result_t split_byte(input logic kind, input logic [DATA_W-1:0] ch);
    split_result_t    r;
    logic [41:0]      kb_cap;
    logic [CNT_W-1:0] pg_cap;
    logic [CNT_W:0]   nxt;
    int               dlen;
    int               m;
    r = '0;
    if (kind == KIND_END) begin
      r.done_res = 1'b1;
      // a partial page counts as a page unless the stream was aborted
      if (stop_st != ST_ABORT && page_bytes != 0) begin
        page_total = sat_inc(page_total);
        if (cfg_sh.delims_per_page > rec_cnt)
          r.last_page_records = cfg_sh.delims_per_page - rec_cnt;
      end
    end else begin
      r.data_out = ch;
      if (stop_st == ST_RUN) begin
        kb_cap = 42'h0_ffff_ffff;
        pg_cap = PAGE_UNLIMITED;
        nxt    = {1'b0, byte_total} + 1'b1;
        if (cfg_sh.size_limit != 0) begin
          if (cfg_sh.limit_in_pages) pg_cap = {1'b0, cfg_sh.size_limit};
          else kb_cap = {11'd0, cfg_sh.size_limit} << KB_SHIFT;
        end
        if ({9'd0, nxt} > kb_cap || nxt > {1'b0, CNT_MAX}) begin
          stop_st = cfg_sh.abort_on_limit ? ST_ABORT : ST_TRUNC;
        end else begin
          dlen         = eff_length();
          m            = int'(match_len);
          byte_total   = nxt[CNT_W-1:0];
          page_bytes   = sat_inc(page_bytes);
          r.write_byte = 1'b1;
          // clamp a match left over from a longer delimiter
          if (m >= dlen) m = dlen - 1;
          if (ch == delim_byte(m)) begin
            m++;
            if (m >= dlen) begin
              m       = 0;
              rec_cnt = rec_cnt + 1'b1;
              if (rec_cnt >= cfg_sh.delims_per_page) begin
                r.page_end = 1'b1;
                page_bytes = '0;
                rec_cnt    = '0;
                page_total = sat_inc(page_total);
                if (page_total > pg_cap) begin
                  stop_st      = cfg_sh.abort_on_limit ? ST_ABORT : ST_TRUNC;
                  r.write_byte = 1'b0;
                end
              end
            end
          end else if (m > 0) begin
            m = prefix_fallback(m, ch);
          end
          match_len = LEN_W'(m);
          hist      = {hist[55:0], ch};
        end
      end
    end
    r.byte_offset = byte_total;
    r.page_count  = page_total;
    r.status      = stop_st;
    if (r.done_res) begin
      match_len  = '0;
      hist       = '0;
      rec_cnt    = '0;
      page_bytes = '0;
      byte_total = '0;
      page_total = '0;
      stop_st    = ST_RUN;
    end
    return r;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_DELIM_BYTES:  cfg_sh.delimiter_bytes  = val;
      REG_DELIM_LENGTH: cfg_sh.delimiter_length = val[LEN_W-1:0];
      REG_DELIMS_PAGE:  cfg_sh.delims_per_page  = val[DPP_W-1:0];
      REG_SIZE_LIMIT:   cfg_sh.size_limit       = val[LIMIT_W-1:0];
      REG_LIMIT_PAGES:  cfg_sh.limit_in_pages   = val[0];
      REG_ABORT_LIMIT:  cfg_sh.abort_on_limit   = val[0];
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // take results and stall the result channel in bursts
  always @(posedge clk) begin : result_check
    split_result_t got;
    split_result_t want;
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = {out_ch.data_out, out_ch.write_byte, out_ch.page_end, out_ch.byte_offset,
             out_ch.page_count, out_ch.last_page_records, out_ch.status, out_ch.done_res};
      if (results_due.size() == 0) begin
        $error("result transaction with none pending: %h", got);
        errors++;
      end else begin
        want = results_due.pop_front();
        check_field("data_out", 64'(want.data_out), 64'(got.data_out));
        check_field("write_byte", 64'(want.write_byte), 64'(got.write_byte));
        check_field("page_end", 64'(want.page_end), 64'(got.page_end));
        check_field("byte_offset", 64'(want.byte_offset), 64'(got.byte_offset));
        check_field("page_count", 64'(want.page_count), 64'(got.page_count));
        check_field("last_page_records", 64'(want.last_page_records),
                    64'(got.last_page_records));
        check_field("status", 64'(want.status), 64'(got.status));
        check_field("done_res", 64'(want.done_res), 64'(got.done_res));
      end
    end
    if (stall_left > 0) begin
      res_ready <= 1'b0;
      stall_left--;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      res_ready  <= 1'b0;
      stall_left = $urandom_range(1, 5) - 1;
    end else begin
      res_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_item(input logic kind, input logic [DATA_W-1:0] data, input bit fixed,
                           input split_result_t want);
    split_result_t r;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= kind;
    in_ch.data_in <= data;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    r = split_byte(kind, data);
    results_due.push_back(fixed ? want : r);
    items_sent++;
  endtask

  // hold off until every pending result has come back and the pipeline is empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_all(input logic [63:0] delim, input logic [3:0] len,
                         input logic [15:0] dpp, input logic [30:0] lim,
                         input logic lip, input logic abort);
    drain();
    write_reg(REG_DELIM_BYTES, delim);
    write_reg(REG_DELIM_LENGTH, {60'd0, len});
    write_reg(REG_DELIMS_PAGE, {48'd0, dpp});
    write_reg(REG_SIZE_LIMIT, {33'd0, lim});
    write_reg(REG_LIMIT_PAGES, {63'd0, lip});
    write_reg(REG_ABORT_LIMIT, {63'd0, abort});
  endtask

  function automatic logic [7:0] alphabet_byte();
    case ($urandom_range(0, 2))
      0:       return 8'h0c;
      1:       return 8'h41;
      default: return 8'h42;
    endcase
  endfunction

  task automatic random_setup();
    logic [63:0] d;
    logic [3:0]  len;
    logic [15:0] dpp;
    logic [30:0] lim;
    logic        lip;
    int          k;
    if ($urandom_range(0, 2) == 0) begin
      d = {$urandom, $urandom};
    end else begin
      for (k = 0; k < 8; k++) d[8*k +: 8] = alphabet_byte();
    end
    len = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                      : 4'($urandom_range(1, MAX_LEN));
    case ($urandom_range(0, 5))
      0:       dpp = 16'd0;
      1:       dpp = 16'hffff;
      default: dpp = 16'($urandom_range(1, 3));
    endcase
    lip = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      2: begin
        lim = 31'($urandom_range(1, 4));
        lip = 1'b1;
      end
      3:       lim = 31'h7fff_ffff;
      default: lim = 31'd0;
    endcase
    set_all(d, len, dpp, lim, lip, 1'($urandom_range(0, 1)));
  endtask

  // mostly whole delimiters, some after a broken prefix, with noise and stream ends between
  task automatic run_stream(input int n_items, input int min_bytes);
    int start;
    int run_len;
    int dl;
    int pick;
    int plen;
    int k;
    start   = items_sent;
    run_len = 0;
    while (items_sent - start < n_items) begin
      dl   = eff_length();
      pick = $urandom_range(0, 9);
      if (pick == 0 && run_len >= min_bytes) begin
        send_item(KIND_END, 8'($urandom_range(0, 255)), 1'b0, '0);
        run_len = 0;
      end else if (pick <= 2) begin
        send_item(KIND_DATA, 8'($urandom_range(0, 255)), 1'b0, '0);
        run_len++;
      end else if (pick <= 4) begin
        repeat ($urandom_range(1, 4)) begin
          send_item(KIND_DATA, delim_byte($urandom_range(0, dl - 1)), 1'b0, '0);
          run_len++;
        end
      end else begin
        plen = $urandom_range(0, dl - 1);
        for (k = 0; k < plen + dl; k++) begin
          send_item(KIND_DATA, delim_byte((k < plen) ? k : k - plen), 1'b0, '0);
          run_len++;
        end
      end
    end
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    opening_rows.push_back({1'b1, idx, val, KIND_DATA, 8'h00, 1'b0, 93'd0});
  endtask

  task automatic add_item(input logic kind, input logic [DATA_W-1:0] data);
    opening_rows.push_back({1'b0, 3'd0, 64'd0, kind, data, 1'b0, 93'd0});
  endtask

  task automatic add_fixed(input logic kind, input logic [DATA_W-1:0] data,
                           input split_result_t want);
    opening_rows.push_back({1'b0, 3'd0, 64'd0, kind, data, 1'b1, want});
  endtask

  initial begin : stimulus
    int ph;
    int i;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.kind    <= KIND_DATA;
    in_ch.data_in <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // register values after reset: form feed delimiter, one per page, no limit
    add_fixed(KIND_DATA, 8'h00, {8'h00, 1'b1, 1'b0, 32'd1, 32'd0, 16'd0, ST_RUN, 1'b0});
    add_fixed(KIND_DATA, 8'hff, {8'hff, 1'b1, 1'b0, 32'd2, 32'd0, 16'd0, ST_RUN, 1'b0});
    add_fixed(KIND_DATA, 8'h0c, {8'h0c, 1'b1, 1'b1, 32'd3, 32'd1, 16'd0, ST_RUN, 1'b0});
    add_fixed(KIND_END, 8'hff, {8'h00, 1'b0, 1'b0, 32'd3, 32'd1, 16'd0, ST_RUN, 1'b1});
    add_fixed(KIND_END, 8'h00, {8'h00, 1'b0, 1'b0, 32'd0, 32'd0, 16'd0, ST_RUN, 1'b1});
    // "ABAC", two per page: fallback to a longer prefix, then a restart at length one
    add_write(REG_DELIM_BYTES, 64'h4341_4241);
    add_write(REG_DELIM_LENGTH, 64'd4);
    add_write(REG_DELIMS_PAGE, 64'd2);
    add_item(KIND_DATA, 8'h41);
    add_item(KIND_DATA, 8'h42);
    add_item(KIND_DATA, 8'h41);
    add_item(KIND_DATA, 8'h42);
    add_item(KIND_DATA, 8'h41);
    add_item(KIND_DATA, 8'h43);
    add_item(KIND_DATA, 8'h41);
    add_item(KIND_DATA, 8'h42);
    add_item(KIND_DATA, 8'h41);
    add_item(KIND_DATA, 8'h41);
    add_item(KIND_DATA, 8'h42);
    // shorten the delimiter under a live match of two
    add_write(REG_DELIM_LENGTH, 64'd2);
    add_item(KIND_DATA, 8'h42);
    add_item(KIND_END, 8'h5a);
    // length zero acts as one; zero delimiters per page closes on every delimiter
    add_write(REG_DELIM_BYTES, 64'h0c);
    add_write(REG_DELIM_LENGTH, 64'd0);
    add_write(REG_DELIMS_PAGE, 64'd0);
    add_item(KIND_DATA, 8'h0c);
    add_item(KIND_DATA, 8'h0c);
    add_item(KIND_END, 8'h00);
    // one-page limit: truncate, then abort
    add_write(REG_SIZE_LIMIT, 64'd1);
    add_write(REG_LIMIT_PAGES, 64'd1);
    add_fixed(KIND_DATA, 8'h0c, {8'h0c, 1'b1, 1'b1, 32'd1, 32'd1, 16'd0, ST_RUN, 1'b0});
    add_fixed(KIND_DATA, 8'h0c, {8'h0c, 1'b0, 1'b1, 32'd2, 32'd2, 16'd0, ST_TRUNC, 1'b0});
    add_fixed(KIND_DATA, 8'h33, {8'h33, 1'b0, 1'b0, 32'd2, 32'd2, 16'd0, ST_TRUNC, 1'b0});
    add_fixed(KIND_END, 8'h00, {8'h00, 1'b0, 1'b0, 32'd2, 32'd2, 16'd0, ST_TRUNC, 1'b1});
    add_write(REG_ABORT_LIMIT, 64'd1);
    add_fixed(KIND_DATA, 8'h0c, {8'h0c, 1'b1, 1'b1, 32'd1, 32'd1, 16'd0, ST_RUN, 1'b0});
    add_fixed(KIND_DATA, 8'h0c, {8'h0c, 1'b0, 1'b1, 32'd2, 32'd2, 16'd0, ST_ABORT, 1'b0});
    add_fixed(KIND_END, 8'h00, {8'h00, 1'b0, 1'b0, 32'd2, 32'd2, 16'd0, ST_ABORT, 1'b1});

    for (i = 0; i < opening_rows.size(); i++) begin
      if (opening_rows[i].is_write) begin
        drain();
        write_reg(opening_rows[i].reg_idx, opening_rows[i].reg_val);
      end else begin
        send_item(opening_rows[i].kind, opening_rows[i].data, opening_rows[i].fixed,
                  opening_rows[i].want);
      end
    end

    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin
          set_all(64'hffff_ffff_ffff_ffff, 4'd8, 16'hffff, 31'h7fff_ffff, 1'b1, 1'b0);
          run_stream(25, 0);
        end
        1: begin
          set_all(64'd0, 4'd15, 16'd0, 31'd0, 1'b0, 1'b1);
          run_stream(25, 0);
        end
        4: begin
          // one kilobyte limit: keep a single stream open past it
          set_all({alphabet_byte(), alphabet_byte(), alphabet_byte(), alphabet_byte(),
                   alphabet_byte(), alphabet_byte(), alphabet_byte(), alphabet_byte()},
                  4'($urandom_range(1, 4)), 16'($urandom_range(1, 3)), 31'd1, 1'b0,
                  1'($urandom_range(0, 1)));
          run_stream(1060, 1030);
        end
        9: begin
          random_setup();
          gaps_on = 1'b0;
          run_stream(60, 0);
        end
        default: begin
          random_setup();
          run_stream(25, 0);
        end
      endcase
    end

    drain();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
src/dps_pkg.sv
src/dps_if.sv
src/dps_front.sv
src/dps_queue.sv
src/dps_back.sv
src/delimiter_page_splitter_top.sv
verif/delimiter_page_splitter_top_tb.sv
